FILE: rtl/core/assert_macros.svh
// assertion macros for the strided element access rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SEA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SEA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEA_ASSERT(label, clk, rst, prop, msg)
`define SEA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/sea_pkg.sv
// types and constants for the strided element access block
`timescale 1ns / 1ps
package sea_pkg;
   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = 16;
   localparam int SIZE_W      = 16;
   localparam int STRIDE_W    = 16;
   localparam int BASE_W      = 12;
   localparam int COUNT_W     = 2;
   localparam int DATA_W      = 64;
   localparam int PROD_W      = IDX_W + STRIDE_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int LANES       = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_COUNT    = 4'd0,
      CSR_DIM_SIZE_0   = 4'd1,
      CSR_DIM_SIZE_1   = 4'd2,
      CSR_DIM_SIZE_2   = 4'd3,
      CSR_DIM_STRIDE_0 = 4'd4,
      CSR_DIM_STRIDE_1 = 4'd5,
      CSR_DIM_STRIDE_2 = 4'd6,
      CSR_BASE_OFFSET  = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_INDEX = 2'd1,
      ST_ADDR  = 2'd2
   } status_type;

   typedef struct packed {
      logic              idx_ok;
      logic              idx_zero;
      logic [PROD_W-1:0] product;
   } lane_result_type;

   typedef struct packed {
      logic              is_write;
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] write_data;
   } merge_result_type;
endpackage

FILE: rtl/core/sea_if.sv
// channel interfaces for requests, responses and register writes
`timescale 1ns / 1ps
interface sea_req_if;
   import sea_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [IDX_W-1:0]     index_0;
   logic [IDX_W-1:0]     index_1;
   logic [IDX_W-1:0]     index_2;
   logic [DATA_W-1:0]    write_data;
   modport source (output valid, action, index_0, index_1, index_2, write_data,
                   input ready);
   modport sink (input valid, action, index_0, index_1, index_2, write_data,
                 output ready);
endinterface

interface sea_rsp_if;
   import sea_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [1:0]        status;
   modport source (output valid, read_data, status, input ready);
   modport sink (input valid, read_data, status, output ready);
endinterface

interface sea_csr_if;
   import sea_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sea_lane.sv
// one dimension lane: index range check and stride product
`timescale 1ns / 1ps
module sea_lane (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        used,
   input  logic [sea_pkg::IDX_W-1:0]    index,
   input  logic [sea_pkg::SIZE_W-1:0]   size,
   input  logic [sea_pkg::STRIDE_W-1:0] stride,
   output sea_pkg::lane_result_type    result
);
   import sea_pkg::*;

   lane_result_type result_ff;
   lane_result_type result_in;

   always_comb begin
      result_in.idx_ok   = !used || (index < size);
      result_in.idx_zero = (index == '0);
      result_in.product  = used ? (PROD_W'(index) * PROD_W'(stride)) : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

FILE: rtl/core/sea_merge.sv
// merging stage: combines lane checks and products into status and address
`timescale 1ns / 1ps
module sea_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   input  logic                              up_write,
   input  logic [sea_pkg::DATA_W-1:0]         up_data,
   input  sea_pkg::lane_result_type          lane_res [sea_pkg::LANES],
   input  logic [sea_pkg::COUNT_W-1:0]        dim_count,
   input  logic [sea_pkg::BASE_W-1:0]         base_offset,
   input  logic                              down_adv,
   output logic                              up_adv,
   output logic                              valid,
   output sea_pkg::merge_result_type         result
);
   import sea_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   merge_result_type result_ff;
   merge_result_type result_in;
   logic [SUM_W-1:0] sum;
   logic             idx_err;
   logic             all_ok;

   assign up_adv = !valid_ff || down_adv;

   always_comb begin
      all_ok = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         all_ok = all_ok && lane_res[i].idx_ok;
      end
      sum = SUM_W'(base_offset) + SUM_W'(lane_res[0].product)
          + SUM_W'(lane_res[1].product) + SUM_W'(lane_res[2].product);
      if (dim_count == '0) begin
         idx_err = !lane_res[0].idx_zero;
         sum     = '0;
      end else begin
         idx_err = !all_ok;
      end
      result_in.is_write   = up_write;
      result_in.write_data = up_data;
      result_in.addr       = sum[ADDR_W-1:0];
      if (idx_err) begin
         result_in.status = ST_INDEX;
      end else if (sum >= SUM_W'(STORE_DEPTH)) begin
         result_in.status = ST_ADDR;
      end else begin
         result_in.status = ST_OK;
      end
      valid_in = up_adv ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_adv) begin
         result_ff <= result_in;
      end
   end

   assign valid  = valid_ff;
   assign result = result_ff;
endmodule

FILE: rtl/core/sea_access.sv
// store access stage: element memory and response register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sea_access (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   input  sea_pkg::merge_result_type up_res,
   output logic                      up_adv,
   sea_rsp_if.source                 rsp_ch
);
   import sea_pkg::*;

   logic [DATA_W-1:0] store_mem [STORE_DEPTH];
   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] rd_data_ff;
   status_type        status_ff;
   logic              write_ff;
   logic              mem_wr;
   logic              mem_rd;
   logic              read_ok;

   assign up_adv   = !valid_ff || rsp_ch.ready;
   assign valid_in = up_adv ? up_valid : valid_ff;
   assign mem_wr   = up_adv && up_valid && (up_res.status == ST_OK) && up_res.is_write;
   assign mem_rd   = up_adv && up_valid && (up_res.status == ST_OK) && !up_res.is_write;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_mem[up_res.addr] <= up_res.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_data_ff <= store_mem[up_res.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_adv) begin
         status_ff <= up_res.status;
         write_ff  <= up_res.is_write;
      end
   end

   assign read_ok          = (status_ff == ST_OK) && !write_ff;
   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.read_data = (valid_ff && read_ok) ? rd_data_ff : '0;

   `SEA_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !valid_ff, "valid after reset")
   `SEA_ASSERT(a_fill_from_merge, clock, reset, $rose(valid_ff) |-> $past(up_valid), "no source")
   `SEA_ASSERT(a_data_only_on_read, clock, reset, (rsp_ch.read_data != '0) |-> read_ok, "stray data")
endmodule

FILE: rtl/core/strided_element_access_top.sv
// top level of the strided element access block
// an accepted request is registered in the lane, merging and access stages in turn
// throughput: one transaction per cycle while the response side takes results
// the three stages are the lane multipliers, the merging adder and the store read port
// reset clears the register file and all stage valids
// store contents are undefined until written; no clearing pass is run
`timescale 1ns / 1ps
module strided_element_access_top (
   input  logic       clock,
   input  logic       reset,
   sea_req_if.sink    req_ch,
   sea_rsp_if.source  rsp_ch,
   sea_csr_if.sink    csr_ch
);
   import sea_pkg::*;

   logic [COUNT_W-1:0]  dim_count_ff;
   logic [SIZE_W-1:0]   dim_size_ff [LANES];
   logic [STRIDE_W-1:0] dim_stride_ff [LANES];
   logic [BASE_W-1:0]   base_offset_ff;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_write_ff;
   logic [DATA_W-1:0]   s1_data_ff;
   logic                s1_adv;
   logic                s2_adv;
   logic                s3_adv;
   logic                s2_valid;
   merge_result_type    s2_res;
   lane_result_type     lane_res [LANES];
   logic [IDX_W-1:0]    lane_index [LANES];

   // register file
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff   <= '0;
         dim_size_ff    <= '{default: '0};
         dim_stride_ff  <= '{default: '0};
         base_offset_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_DIM_COUNT:    dim_count_ff     <= csr_ch.data[COUNT_W-1:0];
            CSR_DIM_SIZE_0:   dim_size_ff[0]   <= csr_ch.data[SIZE_W-1:0];
            CSR_DIM_SIZE_1:   dim_size_ff[1]   <= csr_ch.data[SIZE_W-1:0];
            CSR_DIM_SIZE_2:   dim_size_ff[2]   <= csr_ch.data[SIZE_W-1:0];
            CSR_DIM_STRIDE_0: dim_stride_ff[0] <= csr_ch.data[STRIDE_W-1:0];
            CSR_DIM_STRIDE_1: dim_stride_ff[1] <= csr_ch.data[STRIDE_W-1:0];
            CSR_DIM_STRIDE_2: dim_stride_ff[2] <= csr_ch.data[STRIDE_W-1:0];
            CSR_BASE_OFFSET:  base_offset_ff   <= csr_ch.data[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // lane stage
   assign s1_adv       = !s1_valid_ff || s2_adv;
   assign req_ch.ready = s1_adv;
   assign s1_valid_in  = s1_adv ? req_ch.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_write_ff <= req_ch.action;
         s1_data_ff  <= req_ch.write_data;
      end
   end

   assign lane_index[0] = req_ch.index_0;
   assign lane_index[1] = req_ch.index_1;
   assign lane_index[2] = req_ch.index_2;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      sea_lane u_lane (
         .clock  (clock),
         .load   (s1_adv),
         .used   (dim_count_ff > COUNT_W'(i)),
         .index  (lane_index[i]),
         .size   (dim_size_ff[i]),
         .stride (dim_stride_ff[i]),
         .result (lane_res[i])
      );
   end

   sea_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (s1_valid_ff),
      .up_write    (s1_write_ff),
      .up_data     (s1_data_ff),
      .lane_res    (lane_res),
      .dim_count   (dim_count_ff),
      .base_offset (base_offset_ff),
      .down_adv    (s3_adv),
      .up_adv      (s2_adv),
      .valid       (s2_valid),
      .result      (s2_res)
   );

   sea_access u_access (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_res   (s2_res),
      .up_adv   (s3_adv),
      .rsp_ch   (rsp_ch)
   );
endmodule

FILE: test/strided_element_access_top_tb.sv
// testbench for the strided element access block: directed table then random traffic
`timescale 1ns / 1ps
module strided_element_access_top_tb;
   import sea_pkg::*;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'hF;
   localparam int LATENCY     = 3;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic              action;
      logic [IDX_W-1:0]  index_0;
      logic [IDX_W-1:0]  index_1;
      logic [IDX_W-1:0]  index_2;
      logic [DATA_W-1:0] write_data;
   } access_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      status_type        status;
   } outcome_type;

   typedef struct {
      bit                    is_register;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      access_type            access;
      bit                    typed;
      outcome_type           outcome;
   } step_row_type;

   typedef enum int {SHAPE_TYPICAL, SHAPE_RAW, SHAPE_EXTREME, SHAPE_DENSE} view_shape_type;

   logic clock = 1'b0;
   logic reset;

   sea_req_if req_ch ();
   sea_rsp_if rsp_ch ();
   sea_csr_if csr_ch ();

   strided_element_access_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the register file and the element store
   logic [COUNT_W-1:0]  view_dims;
   logic [SIZE_W-1:0]   view_size [LANES];
   logic [STRIDE_W-1:0] view_stride [LANES];
   logic [BASE_W-1:0]   view_base;
   logic [DATA_W-1:0]   shadow_store [STORE_DEPTH];
   bit                  written [STORE_DEPTH];

   outcome_type  access_outcomes [$];
   step_row_type directed_steps [$];
   int           mismatches = 0;
   int           req_idle_level = 0;
   int           rsp_idle_level = 0;

   function automatic int idle_cycles(int level);
      case (level)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
         default: return $urandom_range(0, 13);
      endcase
   endfunction

   function automatic status_type locate_element(input access_type a,
                                                 output logic [ADDR_W-1:0] addr);
      logic [IDX_W-1:0] idx [LANES];
      longint unsigned  sum;
      idx[0] = a.index_0;
      idx[1] = a.index_1;
      idx[2] = a.index_2;
      addr = '0;
      sum = 0;
      if (view_dims == 0) begin
         if (idx[0] != 0) return ST_INDEX;
      end else begin
         for (int d = 0; d < view_dims; d++)
            if (idx[d] >= view_size[d]) return ST_INDEX;
         sum = 64'(view_base);
         for (int d = 0; d < view_dims; d++)
            sum += 64'(view_stride[d]) * 64'(idx[d]);
      end
      if (sum >= STORE_DEPTH) return ST_ADDR;
      addr = sum[ADDR_W-1:0];
      return ST_OK;
   endfunction

   function automatic outcome_type perform_access(input access_type a);
      outcome_type       o;
      logic [ADDR_W-1:0] addr;
      o.read_data = '0;
      o.status = locate_element(a, addr);
      if (o.status == ST_OK) begin
         if (a.action == ACT_WRITE) begin
            shadow_store[addr] = a.write_data;
            written[addr] = 1'b1;
         end else begin
            o.read_data = shadow_store[addr];
         end
      end
      return o;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_DIM_COUNT:    view_dims = data[COUNT_W-1:0];
         CSR_DIM_SIZE_0:   view_size[0] = data[SIZE_W-1:0];
         CSR_DIM_SIZE_1:   view_size[1] = data[SIZE_W-1:0];
         CSR_DIM_SIZE_2:   view_size[2] = data[SIZE_W-1:0];
         CSR_DIM_STRIDE_0: view_stride[0] = data[STRIDE_W-1:0];
         CSR_DIM_STRIDE_1: view_stride[1] = data[STRIDE_W-1:0];
         CSR_DIM_STRIDE_2: view_stride[2] = data[STRIDE_W-1:0];
         CSR_BASE_OFFSET:  view_base = data[BASE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic step_row_type access_row(logic act, logic [IDX_W-1:0] i0,
                                               logic [IDX_W-1:0] i1, logic [IDX_W-1:0] i2,
                                               logic [DATA_W-1:0] wd, bit typed = 1'b0,
                                               logic [DATA_W-1:0] rd = '0,
                                               status_type st = ST_OK);
      step_row_type r;
      r.is_register = 1'b0;
      r.reg_index = '0;
      r.reg_data = '0;
      r.access = '{action: act, index_0: i0, index_1: i1, index_2: i2, write_data: wd};
      r.typed = typed;
      r.outcome = '{read_data: rd, status: st};
      return r;
   endfunction

   function automatic step_row_type register_row(logic [CSR_IDX_W-1:0] index,
                                                 logic [CSR_DATA_W-1:0] data);
      step_row_type r;
      r = access_row(ACT_READ, '0, '0, '0, '0);
      r.is_register = 1'b1;
      r.reg_index = index;
      r.reg_data = data;
      return r;
   endfunction

   function automatic logic [15:0] extreme_value();
      case ($urandom_range(0, 2))
         0: return 16'h0000;
         1: return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic wait_idle();
      while (access_outcomes.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_ch.index = index;
      csr_ch.data = data;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      apply_register(index, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic issue_access(access_type a, bit typed, outcome_type typed_outcome);
      outcome_type o;
      repeat (idle_cycles(req_idle_level)) @(negedge clock);
      req_ch.action = a.action;
      req_ch.index_0 = a.index_0;
      req_ch.index_1 = a.index_1;
      req_ch.index_2 = a.index_2;
      req_ch.write_data = a.write_data;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      o = perform_access(a);
      access_outcomes.push_back(typed ? typed_outcome : o);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   function automatic access_type random_access();
      access_type       a;
      logic [IDX_W-1:0] idx [LANES];
      for (int d = 0; d < LANES; d++) begin
         if (d < view_dims && view_size[d] != 0 && $urandom_range(0, 9) != 0)
            idx[d] = IDX_W'($urandom_range(0, view_size[d] - 1));
         else if (view_dims == 0 && d == 0 && $urandom_range(0, 7) != 0)
            idx[d] = '0;
         else
            idx[d] = IDX_W'($urandom);
      end
      a.action = ($urandom_range(0, 1) == 1) ? ACT_WRITE : ACT_READ;
      a.index_0 = idx[0];
      a.index_1 = idx[1];
      a.index_2 = idx[2];
      a.write_data = {$urandom, $urandom};
      return a;
   endfunction

   task automatic random_phase(int count);
      logic [CSR_DATA_W-1:0] plan [8];
      view_shape_type        shape;
      access_type            a;
      logic [ADDR_W-1:0]     addr;
      shape = view_shape_type'($urandom_range(0, 3));
      case (shape)
         SHAPE_TYPICAL: begin
            plan[0] = 16'($urandom_range(0, 3));
            for (int d = 0; d < LANES; d++) begin
               plan[1 + d] = 16'($urandom_range(1, 24));
               plan[4 + d] = 16'($urandom_range(0, 40));
            end
            plan[7] = 16'($urandom_range(0, 3000));
         end
         SHAPE_RAW: begin
            for (int r = 0; r < 8; r++) plan[r] = 16'($urandom);
         end
         SHAPE_EXTREME: begin
            plan[0] = 16'($urandom_range(1, 3));
            for (int r = 1; r < 7; r++) plan[r] = extreme_value();
            plan[7] = ($urandom_range(0, 1) == 1) ? 16'h0FFF : 16'h0000;
         end
         default: begin
            plan[0] = 16'd3;
            plan[1] = 16'd8;
            plan[2] = 16'd8;
            plan[3] = 16'd8;
            plan[4] = 16'd1;
            plan[5] = 16'd8;
            plan[6] = 16'd64;
            plan[7] = 16'($urandom_range(0, 3584));
         end
      endcase
      wait_idle();
      for (int r = 0; r < 8; r++) write_register(csr_index_type'(r), plan[r]);
      if ($urandom_range(0, 3) == 0) write_register(CSR_SPARE, 16'($urandom));
      req_idle_level = $urandom_range(0, 2);
      rsp_idle_level = $urandom_range(0, 2);
      for (int n = 0; n < count; n++) begin
         a = random_access();
         // never read a word that has not been written
         if (a.action == ACT_READ && locate_element(a, addr) == ST_OK && !written[addr])
            a.action = ACT_WRITE;
         issue_access(a, 1'b0, '0);
      end
   endtask

   task automatic load_directed();
      // scalar view straight after reset
      directed_steps.push_back(access_row(ACT_WRITE, 16'h0000, 16'h0000, 16'h0000,
         64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, ST_OK));
      directed_steps.push_back(access_row(ACT_READ, 16'h0000, 16'h0000, 16'h0000,
         64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK));
      directed_steps.push_back(access_row(ACT_READ, 16'h0001, 16'h0000, 16'h0000,
         64'h0, 1'b1, 64'h0, ST_INDEX));
      directed_steps.push_back(access_row(ACT_WRITE, 16'hFFFF, 16'h0000, 16'h0000,
         64'h5555_AAAA_5555_AAAA, 1'b1, 64'h0, ST_INDEX));
      directed_steps.push_back(access_row(ACT_READ, 16'h0000, 16'hFFFF, 16'hFFFF,
         64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK));
      // three dimensions near the top of the store
      directed_steps.push_back(register_row(CSR_DIM_COUNT, 16'd3));
      directed_steps.push_back(register_row(CSR_DIM_SIZE_0, 16'd16));
      directed_steps.push_back(register_row(CSR_DIM_SIZE_1, 16'd8));
      directed_steps.push_back(register_row(CSR_DIM_SIZE_2, 16'd4));
      directed_steps.push_back(register_row(CSR_DIM_STRIDE_0, 16'd1));
      directed_steps.push_back(register_row(CSR_DIM_STRIDE_1, 16'd16));
      directed_steps.push_back(register_row(CSR_DIM_STRIDE_2, 16'd128));
      directed_steps.push_back(register_row(CSR_BASE_OFFSET, 16'hFF00));
      directed_steps.push_back(access_row(ACT_WRITE, 16'd0, 16'd0, 16'd0,
         64'h0123_4567_89AB_CDEF));
      directed_steps.push_back(access_row(ACT_READ, 16'd0, 16'd0, 16'd0, 64'h0));
      directed_steps.push_back(access_row(ACT_WRITE, 16'd15, 16'd7, 16'd3,
         64'hDEAD_BEEF_DEAD_BEEF, 1'b1, 64'h0, ST_ADDR));
      directed_steps.push_back(access_row(ACT_READ, 16'd16, 16'd0, 16'd0,
         64'h0, 1'b1, 64'h0, ST_INDEX));
      directed_steps.push_back(access_row(ACT_READ, 16'd0, 16'd8, 16'd0,
         64'h0, 1'b1, 64'h0, ST_INDEX));
      directed_steps.push_back(access_row(ACT_READ, 16'd0, 16'd0, 16'd4,
         64'h0, 1'b1, 64'h0, ST_INDEX));
      // index error wins over address error
      directed_steps.push_back(access_row(ACT_READ, 16'd15, 16'd7, 16'd4,
         64'h0, 1'b1, 64'h0, ST_INDEX));
      directed_steps.push_back(access_row(ACT_WRITE, 16'd15, 16'd1, 16'd1,
         64'h8000_0000_0000_0001));
      directed_steps.push_back(access_row(ACT_READ, 16'd15, 16'd1, 16'd1, 64'h0));
      // zero extent
      directed_steps.push_back(register_row(CSR_DIM_COUNT, 16'd1));
      directed_steps.push_back(register_row(CSR_DIM_SIZE_0, 16'd0));
      directed_steps.push_back(access_row(ACT_READ, 16'd0, 16'd0, 16'd0,
         64'h0, 1'b1, 64'h0, ST_INDEX));
      // full-width strides
      directed_steps.push_back(register_row(CSR_DIM_SIZE_0, 16'hFFFF));
      directed_steps.push_back(register_row(CSR_DIM_STRIDE_0, 16'hFFFF));
      directed_steps.push_back(register_row(CSR_BASE_OFFSET, 16'h0000));
      directed_steps.push_back(access_row(ACT_WRITE, 16'd0, 16'd0, 16'd0,
         64'hA5A5_5A5A_0F0F_F0F0));
      directed_steps.push_back(access_row(ACT_WRITE, 16'hFFFE, 16'd0, 16'd0,
         64'h1, 1'b1, 64'h0, ST_ADDR));
      directed_steps.push_back(access_row(ACT_READ, 16'd1, 16'd0, 16'd0,
         64'h0, 1'b1, 64'h0, ST_ADDR));
      directed_steps.push_back(access_row(ACT_READ, 16'd0, 16'd0, 16'd0, 64'h0));
      // masked register values, spare index, zero strides at the last word
      directed_steps.push_back(register_row(CSR_SPARE, 16'hFFFF));
      directed_steps.push_back(register_row(CSR_DIM_COUNT, 16'hFFFE));
      directed_steps.push_back(register_row(CSR_DIM_SIZE_1, 16'hFFFF));
      directed_steps.push_back(register_row(CSR_DIM_STRIDE_0, 16'h0000));
      directed_steps.push_back(register_row(CSR_DIM_STRIDE_1, 16'h0000));
      directed_steps.push_back(register_row(CSR_BASE_OFFSET, 16'hFFFF));
      directed_steps.push_back(access_row(ACT_WRITE, 16'hFFFE, 16'hFFFE, 16'hFFFF,
         64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 64'h0, ST_OK));
      directed_steps.push_back(access_row(ACT_READ, 16'd1, 16'd2, 16'hFFFF, 64'h0));
   endtask

   // response side
   initial begin
      int rsp_wait;
      rsp_ch.ready = 1'b0;
      forever begin
         rsp_wait = idle_cycles(rsp_idle_level);
         if (rsp_wait != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (rsp_wait) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (access_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: read_data %h status %0d",
                        rsp_ch.read_data, rsp_ch.status);
         end else begin
            want = access_outcomes.pop_front();
            if (rsp_ch.read_data !== want.read_data || rsp_ch.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: read_data exp %h got %h, status exp %0d got %0d",
                           want.read_data, rsp_ch.read_data, want.status, rsp_ch.status);
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      step_row_type row;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_READ;
      req_ch.index_0 = '0;
      req_ch.index_1 = '0;
      req_ch.index_2 = '0;
      req_ch.write_data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      view_dims = '0;
      view_base = '0;
      for (int d = 0; d < LANES; d++) begin
         view_size[d] = '0;
         view_stride[d] = '0;
      end
      for (int w = 0; w < STORE_DEPTH; w++) begin
         shadow_store[w] = '0;
         written[w] = 1'b0;
      end
      load_directed();
      repeat (6) @(negedge clock);
      reset = 1'b0;
      req_idle_level = 1;
      rsp_idle_level = 1;
      foreach (directed_steps[s]) begin
         row = directed_steps[s];
         if (row.is_register) begin
            wait_idle();
            write_register(row.reg_index, row.reg_data);
         end else begin
            issue_access(row.access, row.typed, row.outcome);
         end
      end
      for (int p = 0; p < PHASES; p++) random_phase(PHASE_ITEMS);
      wait_idle();
      repeat (LATENCY + 5) @(negedge clock);
      if (mismatches == 0 && access_outcomes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
